// ===== src/mdp_pkg.sv =====
// Shared types, field positions and codes for the microprogrammed datapath step.
package mdp_pkg;

  // Memory size and derived address width
  localparam int MEM_WORDS = 8;
  localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // Field widths
  localparam int WORD_W  = 32;
  localparam int MW_W    = 23;
  localparam int IDX_W   = 4;
  localparam int MODE_W  = 2;
  localparam int MBR_W   = 8;

  // Stream data widths (whole bytes)
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 328;

  // Input tdata layout
  localparam int IN_MW_LO  = 0;
  localparam int IN_IDX_LO = IN_MW_LO + MW_W;
  localparam int IN_VAL_LO = IN_IDX_LO + IDX_W;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_EXEC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LDMEM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LDREG = 2'd2;

  // Microword bit positions
  localparam int MW_SLL8  = 22;
  localparam int MW_SRA1  = 21;
  localparam int MW_F0    = 20;
  localparam int MW_F1    = 19;
  localparam int MW_ENA   = 18;
  localparam int MW_ENB   = 17;
  localparam int MW_INVA  = 16;
  localparam int MW_INC   = 15;
  localparam int MW_C_MAR = 14;
  localparam int MW_C_MDR = 13;
  localparam int MW_C_PC  = 12;
  localparam int MW_C_SP  = 11;
  localparam int MW_C_LV  = 10;
  localparam int MW_C_CPP = 9;
  localparam int MW_C_TOS = 8;
  localparam int MW_C_OPC = 7;
  localparam int MW_C_H   = 6;
  localparam int MW_WRITE = 5;
  localparam int MW_READ  = 4;
  localparam int MW_BSEL_HI = 3;
  localparam int MW_TOP_HI  = 22;
  localparam int MW_TOP_LO  = 15;

  // B bus selects
  localparam logic [3:0] BSEL_MDR  = 4'd0;
  localparam logic [3:0] BSEL_PC   = 4'd1;
  localparam logic [3:0] BSEL_MBRS = 4'd2;
  localparam logic [3:0] BSEL_MBRU = 4'd3;
  localparam logic [3:0] BSEL_SP   = 4'd4;
  localparam logic [3:0] BSEL_LV   = 4'd5;
  localparam logic [3:0] BSEL_CPP  = 4'd6;
  localparam logic [3:0] BSEL_TOS  = 4'd7;
  localparam logic [3:0] BSEL_OPC  = 4'd8;

  // ALU functions, {F0, F1}
  localparam logic [1:0] ALU_AND  = 2'b00;
  localparam logic [1:0] ALU_OR   = 2'b01;
  localparam logic [1:0] ALU_NOTB = 2'b10;
  localparam logic [1:0] ALU_ADD  = 2'b11;

  // Register indexes for register loads
  localparam logic [IDX_W-1:0] RIDX_MAR = 4'd0;
  localparam logic [IDX_W-1:0] RIDX_MDR = 4'd1;
  localparam logic [IDX_W-1:0] RIDX_PC  = 4'd2;
  localparam logic [IDX_W-1:0] RIDX_MBR = 4'd3;
  localparam logic [IDX_W-1:0] RIDX_SP  = 4'd4;
  localparam logic [IDX_W-1:0] RIDX_LV  = 4'd5;
  localparam logic [IDX_W-1:0] RIDX_CPP = 4'd6;
  localparam logic [IDX_W-1:0] RIDX_TOS = 4'd7;
  localparam logic [IDX_W-1:0] RIDX_OPC = 4'd8;
  localparam logic [IDX_W-1:0] RIDX_H   = 4'd9;

  // Register file of the datapath
  typedef struct packed {
    logic [WORD_W-1:0] mar;
    logic [WORD_W-1:0] mdr;
    logic [WORD_W-1:0] pc;
    logic [MBR_W-1:0]  mbr;
    logic [WORD_W-1:0] sp;
    logic [WORD_W-1:0] lv;
    logic [WORD_W-1:0] cpp;
    logic [WORD_W-1:0] tos;
    logic [WORD_W-1:0] opc;
    logic [WORD_W-1:0] h;
  } regs_t;

  // Memory access request
  typedef struct packed {
    logic              we;
    logic              re;
    logic [MEM_AW-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== src/mdp_alu.sv =====
// B bus select, ALU and shifter of the datapath.
module mdp_alu (
  input  logic [mdp_pkg::MW_W-1:0]   microword,
  input  mdp_pkg::regs_t             regs,
  output logic [mdp_pkg::WORD_W-1:0] shifter_out
);
  import mdp_pkg::*;

  logic [WORD_W-1:0] bbus;
  logic [WORD_W-1:0] a_in;
  logic [WORD_W-1:0] b_in;
  logic [WORD_W-1:0] alu_s;
  logic [WORD_W-1:0] alu_r;
  logic [1:0]        alu_f;

  // Drive the B bus
  always_comb begin
    case (microword[MW_BSEL_HI:0])
      BSEL_MDR:  bbus = regs.mdr;
      BSEL_PC:   bbus = regs.pc;
      BSEL_MBRS: bbus = {{(WORD_W-MBR_W){regs.mbr[MBR_W-1]}}, regs.mbr};
      BSEL_MBRU: bbus = {{(WORD_W-MBR_W){1'b0}}, regs.mbr};
      BSEL_SP:   bbus = regs.sp;
      BSEL_LV:   bbus = regs.lv;
      BSEL_CPP:  bbus = regs.cpp;
      BSEL_TOS:  bbus = regs.tos;
      BSEL_OPC:  bbus = regs.opc;
      default:   bbus = '0;
    endcase
  end

  // Gate and combine the operands
  always_comb begin
    a_in  = microword[MW_ENA] ? regs.h : '0;
    if (microword[MW_INVA]) begin
      a_in = ~a_in;
    end
    b_in  = microword[MW_ENB] ? bbus : '0;
    alu_f = {microword[MW_F0], microword[MW_F1]};
    case (alu_f)
      ALU_AND:  alu_s = a_in & b_in;
      ALU_OR:   alu_s = a_in | b_in;
      ALU_NOTB: alu_s = ~b_in;
      ALU_ADD:  alu_s = a_in + b_in;
      default:  alu_s = a_in + b_in;
    endcase
    alu_r = alu_s + {{(WORD_W-1){1'b0}}, microword[MW_INC]};
  end

  // Shift: left by 8 wins over arithmetic right by 1
  always_comb begin
    if (microword[MW_SLL8]) begin
      shifter_out = {alu_r[WORD_W-9:0], 8'h00};
    end else if (microword[MW_SRA1]) begin
      shifter_out = {alu_r[WORD_W-1], alu_r[WORD_W-1:1]};
    end else begin
      shifter_out = alu_r;
    end
  end

endmodule

// ===== src/mdp_mem.sv =====
// Main memory with registered read data and per-word written flags.
module mdp_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mdp_pkg::mem_req_t          req,
  output logic [mdp_pkg::WORD_W-1:0] rdata
);
  import mdp_pkg::*;

  logic [WORD_W-1:0]    mem_r [MEM_WORDS];
  logic [MEM_WORDS-1:0] written_r;
  logic [WORD_W-1:0]    rdata_r;
  logic                 rd_written_r;

  // Track which words hold written data; others read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (req.we) begin
        written_r[req.addr] <= 1'b1;
      end
      if (req.re) begin
        rd_written_r <= written_r[req.addr];
      end
    end
  end

  // Write and read the storage array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem_r[req.addr];
    end
  end

  assign rdata = rd_written_r ? rdata_r : '0;

endmodule

// ===== src/microprogrammed_datapath_step.sv =====
// Top level of the microprogrammed datapath step: register file, memory and output stage.
//
//  channel | ports                  | carries
//  --------+------------------------+------------------------------------------------
//  input   | in_tvalid/tready/tdata | tdata: microword, target_index, load_value
//          | in_tuser               | tuser: mode
//  result  | out_tvalid/tready/tdata| tdata: shifter_out, mar..h register values
//          | out_tuser              | tuser: is_fetch
//
// One item per clock cycle while the output is not stalled; a result passes through
// the result stage and the output register, so a synchronous memory read can land in MDR.
// A pending read forwards into MDR for the next item, so no bubble is needed.
// Reset clears the architectural registers, the handshake flags and the memory's written flags.
// A stalled result holds in the output register; one more item may be taken
// behind it before the input stalls.
module microprogrammed_datapath_step (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mdp_pkg::IN_DATA_W-1:0]  in_tdata,   // microword, target_index, load_value, zero pad
  input  logic [mdp_pkg::MODE_W-1:0]     in_tuser,   // mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mdp_pkg::OUT_DATA_W-1:0] out_tdata,  // shifter_out, mar, mdr, pc, mbr, sp, lv,
                                                     // cpp, tos, opc, h
  output logic [0:0]                     out_tuser   // is_fetch
);
  import mdp_pkg::*;

  // Input fields
  logic [MW_W-1:0]   mw;
  logic [IDX_W-1:0]  idx;
  logic [WORD_W-1:0] load_value;
  logic [MODE_W-1:0] mode;

  // Architectural state
  regs_t regs_r;
  regs_t regs_nxt;
  regs_t regs_eff;
  logic  pend_r;
  logic  pend_nxt;

  // Result stage and output register
  logic                  valid_a_r;
  logic [WORD_W-1:0]     sh_a_r;
  logic [WORD_W-1:0]     sh_nxt;
  logic                  fetch_a_r;
  logic                  fetch_nxt;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_fetch_r;

  logic              in_xfer;
  logic              move;
  logic [WORD_W-1:0] alu_sh;
  logic [WORD_W-1:0] mem_rdata;
  logic              mar_hit;
  mem_req_t          mem_req;

  assign mw         = in_tdata[IN_MW_LO +: MW_W];
  assign idx        = in_tdata[IN_IDX_LO +: IDX_W];
  assign load_value = in_tdata[IN_VAL_LO +: WORD_W];
  assign mode       = in_tuser;

  // Handshake: result stage drains into output register
  assign move      = valid_a_r && (!out_valid_r || out_tready);
  assign in_tready = !valid_a_r || move;
  assign in_xfer   = in_tvalid && in_tready;

  // Forward a pending memory read into MDR
  always_comb begin
    regs_eff     = regs_r;
    regs_eff.mdr = pend_r ? mem_rdata : regs_r.mdr;
  end

  mdp_alu u_alu (
    .microword   (mw),
    .regs        (regs_eff),
    .shifter_out (alu_sh)
  );

  // Next state for the item at the input
  always_comb begin
    regs_nxt  = regs_eff;
    pend_nxt  = 1'b0;
    sh_nxt    = '0;
    fetch_nxt = 1'b0;
    mar_hit   = 1'b0;
    mem_req   = '0;
    case (mode)
      MODE_EXEC: begin
        if (mw[MW_WRITE] && mw[MW_READ]) begin
          regs_nxt.mbr = mw[MW_TOP_HI:MW_TOP_LO];
          regs_nxt.h   = {{(WORD_W-MBR_W){1'b0}}, mw[MW_TOP_HI:MW_TOP_LO]};
          fetch_nxt    = 1'b1;
        end else begin
          sh_nxt = alu_sh;
          if (mw[MW_C_H])   regs_nxt.h   = alu_sh;
          if (mw[MW_C_OPC]) regs_nxt.opc = alu_sh;
          if (mw[MW_C_TOS]) regs_nxt.tos = alu_sh;
          if (mw[MW_C_CPP]) regs_nxt.cpp = alu_sh;
          if (mw[MW_C_LV])  regs_nxt.lv  = alu_sh;
          if (mw[MW_C_SP])  regs_nxt.sp  = alu_sh;
          if (mw[MW_C_PC])  regs_nxt.pc  = alu_sh;
          if (mw[MW_C_MDR]) regs_nxt.mdr = alu_sh;
          if (mw[MW_C_MAR]) regs_nxt.mar = alu_sh;
          mar_hit       = regs_nxt.mar < WORD_W'(MEM_WORDS);
          mem_req.addr  = regs_nxt.mar[MEM_AW-1:0];
          mem_req.wdata = regs_nxt.mdr;
          mem_req.we    = in_xfer && mar_hit && mw[MW_WRITE];
          mem_req.re    = in_xfer && mar_hit && mw[MW_READ];
          pend_nxt      = mar_hit && mw[MW_READ];
        end
      end
      MODE_LDMEM: begin
        mem_req.addr  = MEM_AW'(idx);
        mem_req.wdata = load_value;
        mem_req.we    = in_xfer && (WORD_W'(idx) < WORD_W'(MEM_WORDS));
      end
      MODE_LDREG: begin
        case (idx)
          RIDX_MAR: regs_nxt.mar = load_value;
          RIDX_MDR: regs_nxt.mdr = load_value;
          RIDX_PC:  regs_nxt.pc  = load_value;
          RIDX_MBR: regs_nxt.mbr = load_value[MBR_W-1:0];
          RIDX_SP:  regs_nxt.sp  = load_value;
          RIDX_LV:  regs_nxt.lv  = load_value;
          RIDX_CPP: regs_nxt.cpp = load_value;
          RIDX_TOS: regs_nxt.tos = load_value;
          RIDX_OPC: regs_nxt.opc = load_value;
          RIDX_H:   regs_nxt.h   = load_value;
          default:  ;
        endcase
      end
      default: ;
    endcase
  end

  mdp_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Advance state and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r      <= '0;
      pend_r      <= 1'b0;
      valid_a_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        regs_r <= regs_nxt;
        pend_r <= pend_nxt;
      end
      if (in_xfer) begin
        valid_a_r <= 1'b1;
      end else if (move) begin
        valid_a_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold per-item results; capture the finished step into the output register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sh_a_r    <= sh_nxt;
      fetch_a_r <= fetch_nxt;
    end
    if (move) begin
      out_data_r  <= {regs_eff.h, regs_eff.opc, regs_eff.tos, regs_eff.cpp, regs_eff.lv,
                      regs_eff.sp, regs_eff.mbr, regs_eff.pc, regs_eff.mdr, regs_eff.mar,
                      sh_a_r};
      out_fetch_r <= fetch_a_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_fetch_r;

endmodule
